// ----- rtl/core/xcfp_pkg.sv -----
package xcfp_pkg;

  localparam logic [7:0]  HeaderByte     = 8'hFF;
  localparam logic [15:0] MinFrameLength = 16'd2;
  localparam logic [15:0] MaxLengthReset = 16'd13;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StBadHeader   = 2'd1,
    StBadChecksum = 2'd2,
    StBadLength   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [7:0] sequence_res;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

// ----- rtl/core/xor_checked_frame_parser.sv -----
// byte-serial parser for length-prefixed frames with an xor checksum
// input channel: one frame byte per transaction, frame_start marks the
// first byte of a frame; a start inside a frame drops that frame silently
// output channel: one result per frame (ok, bad header, bad checksum,
// bad length) with the command byte and the last good sequence byte
// config: cfg_we_i writes the largest accepted length from cfg_data_i;
// the user must write it only while no frame byte is in flight, and the block does not enforce this
// a byte taken lands in the input register, is parsed from there by the
// parse stage, and any result is captured in the result register and
// presented on out_valid_o
// throughput: one byte per cycle while the parse stage is not stalled,
// set by the single parse stage between the input register and the
// result register; a waiting result stalls the parse stage only if the
// next byte also produces a result; in_ready_o drops once the input
// register is full and cannot move on
// reset: parser idle, stored sequence zero, length limit 13, both
// channels empty
module xor_checked_frame_parser import xcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      fire;
  step_res_t res;

  assign fire       = in_valid_q & (~out_valid_q | out_ready_i | ~res.valid);
  assign in_ready_o = ~in_valid_q | fire;

  xcfp_parse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .item_i     (in_data_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire && res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (fire && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/xcfp_parse_core.sv -----
module xcfp_parse_core import xcfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output step_res_t res_o
);

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhHdrGood = 3'd1,
    PhHdrBad  = 3'd2,
    PhLenHi   = 3'd3,
    PhLenLo   = 3'd4,
    PhPayload = 3'd5,
    PhCheck   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  pcmd_q, pcmd_d;
  logic [7:0]  pseq_q, pseq_d;
  logic [7:0]  last_q, last_d;
  logic [15:0] max_len_q;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [7:0]  seq_v;
  logic        emit;
  status_e     status;
  logic [7:0]  command;

  assign b         = item_i.data_byte;
  assign len_full  = {len_q[15:8], b};
  assign count_inc = count_q + 16'd1;
  assign seq_v     = (len_q == MinFrameLength) ? b : pseq_q;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    xor_d   = xor_q;
    pcmd_d  = pcmd_q;
    pseq_d  = pseq_q;
    last_d  = last_q;
    emit    = 1'b0;
    status  = StOk;
    command = 8'd0;
    if (item_i.frame_start) begin
      count_d = '0;
      xor_d   = '0;
      pcmd_d  = '0;
      pseq_d  = '0;
      len_d   = '0;
      phase_d = (b == HeaderByte) ? PhHdrGood : PhHdrBad;
    end else begin
      unique case (phase_q)
        PhHdrGood, PhHdrBad: begin
          if (phase_q == PhHdrBad || b != HeaderByte) begin
            emit    = 1'b1;
            status  = StBadHeader;
            phase_d = PhIdle;
          end else begin
            phase_d = PhLenHi;
          end
        end
        PhLenHi: begin
          len_d   = {b, 8'd0};
          xor_d   = b;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d = len_full;
          xor_d = xor_q ^ b;
          if (len_full < MinFrameLength || len_full > max_len_q) begin
            emit    = 1'b1;
            status  = StBadLength;
            phase_d = PhIdle;
          end else begin
            count_d = '0;
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          if (count_q == 16'd0) begin
            pcmd_d = b;
          end else if (count_q == 16'd1) begin
            pseq_d = b;
          end
          xor_d   = xor_q ^ b;
          count_d = count_inc;
          if (count_inc >= len_q - 16'd1) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          pseq_d  = seq_v;
          emit    = 1'b1;
          phase_d = PhIdle;
          if (b != xor_q) begin
            status = StBadChecksum;
          end else begin
            status  = StOk;
            command = pcmd_q;
            last_d  = seq_v;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_comb begin
    res_o.valid             = emit;
    res_o.item.status       = status;
    res_o.item.command      = command;
    res_o.item.sequence_res = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      count_q   <= '0;
      len_q     <= '0;
      xor_q     <= '0;
      pcmd_q    <= '0;
      pseq_q    <= '0;
      last_q    <= '0;
      max_len_q <= MaxLengthReset;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        len_q   <= len_d;
        xor_q   <= xor_d;
        pcmd_q  <= pcmd_d;
        pseq_q  <= pseq_d;
        last_q  <= last_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // any result ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid) |=> phase_q == PhIdle)
    else $error("parser not idle after result");

  // failed frames carry no command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.item.status != StOk) |-> res_o.item.command == 8'd0)
    else $error("command on failed frame");

  // payload count never reaches the checksum position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> count_q < len_q - 16'd1)
    else $error("payload count overrun");

  // stored sequence only moves on a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && res_o.valid && res_o.item.status == StOk) |=> $stable(last_q))
    else $error("sequence changed without good frame");
`endif

endmodule
